[rtl/core/c8x_pkg.sv]
package c8x_pkg;

    localparam int ADDR_W      = 12;
    localparam int REG_AW      = 4;
    localparam int NUM_REGS    = 16;
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH);

    localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;
    localparam logic [REG_AW-1:0] VF_IDX   = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    // instruction classes (high nibble)
    localparam logic [3:0] CLS_SYS  = 4'h0;
    localparam logic [3:0] CLS_JP   = 4'h1;
    localparam logic [3:0] CLS_CALL = 4'h2;
    localparam logic [3:0] CLS_SE   = 4'h3;
    localparam logic [3:0] CLS_SNE  = 4'h4;
    localparam logic [3:0] CLS_SER  = 4'h5;
    localparam logic [3:0] CLS_LD   = 4'h6;
    localparam logic [3:0] CLS_ADD  = 4'h7;
    localparam logic [3:0] CLS_ALU  = 4'h8;
    localparam logic [3:0] CLS_SNER = 4'h9;
    localparam logic [3:0] CLS_LDI  = 4'hA;
    localparam logic [3:0] CLS_JPV0 = 4'hB;
    localparam logic [3:0] CLS_RND  = 4'hC;

    // 8xyn sub-operations
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    typedef struct packed {
        logic [15:0] instruction;
        logic [7:0]  random_byte;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0] next_pc;
        logic [ADDR_W-1:0] index_value;
        logic              reg_written;
        logic [REG_AW-1:0] dest_reg;
        logic [7:0]        dest_value;
        logic              flag_written;
        logic              flag_value;
        logic              clear_screen;
        logic              unsupported;
    } t_out;

    // state update produced by the execute logic
    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] index;
        logic [SP_W-1:0]   sp;
        logic              stk_we;
        logic [ADDR_W-1:0] stk_wdata;
        logic              wr;
        logic [REG_AW-1:0] x;
        logic [7:0]        dval;
        logic              fw;
        logic              fval;
        logic              clr;
        logic              unsup;
    } t_exec_res;

    function automatic logic [SP_W-1:0] sp_inc(input logic [SP_W-1:0] sp);
        logic [SP_W-1:0] r;
        if (sp == SP_W'(STACK_DEPTH - 1)) r = '0;
        else                              r = sp + 1'b1;
        return r;
    endfunction

    function automatic logic [SP_W-1:0] sp_dec(input logic [SP_W-1:0] sp);
        logic [SP_W-1:0] r;
        if (sp == '0) r = SP_W'(STACK_DEPTH - 1);
        else          r = sp - 1'b1;
        return r;
    endfunction

endpackage

[rtl/core/c8x_ram.sv]
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/c8x_exec.sv]
module c8x_exec (
    input  c8x_pkg::t_in                       i_req,
    input  logic [7:0]                         i_vx,
    input  logic [7:0]                         i_vy,
    input  logic [c8x_pkg::ADDR_W-1:0]         i_pc,
    input  logic [c8x_pkg::ADDR_W-1:0]         i_index,
    input  logic [c8x_pkg::SP_W-1:0]           i_sp,
    input  logic [c8x_pkg::SP_W-1:0]           i_ret_sp,
    input  logic [c8x_pkg::ADDR_W-1:0]         i_stk_data,
    output c8x_pkg::t_exec_res                 o_res
);
    import c8x_pkg::*;

    logic [3:0]        cls;
    logic [3:0]        n;
    logic [7:0]        kk;
    logic [ADDR_W-1:0] nnn;
    logic [ADDR_W-1:0] pc2;
    logic [ADDR_W-1:0] pc4;
    logic [8:0]        sum;

    assign cls = i_req.instruction[15:12];
    assign n   = i_req.instruction[3:0];
    assign kk  = i_req.instruction[7:0];
    assign nnn = i_req.instruction[ADDR_W-1:0];
    assign pc2 = i_pc + ADDR_W'(2);
    assign pc4 = i_pc + ADDR_W'(4);
    assign sum = {1'b0, i_vx} + {1'b0, i_vy};

    always_comb begin
        o_res           = '0;
        o_res.pc        = pc2;
        o_res.index     = i_index;
        o_res.sp        = i_sp;
        o_res.stk_wdata = pc2;
        o_res.x         = i_req.instruction[11:8];

        unique case (cls)
            CLS_SYS: begin
                if (i_req.instruction == OP_CLS) begin
                    o_res.clr = 1'b1;
                end else if (i_req.instruction == OP_RET) begin
                    o_res.sp = i_ret_sp;
                    o_res.pc = i_stk_data;
                end else begin
                    o_res.unsup = 1'b1;
                end
            end
            CLS_JP: o_res.pc = nnn;
            CLS_CALL: begin
                o_res.stk_we = 1'b1;
                o_res.sp     = sp_inc(i_sp);
                o_res.pc     = nnn;
            end
            CLS_SE:  if (i_vx == kk) o_res.pc = pc4;
            CLS_SNE: if (i_vx != kk) o_res.pc = pc4;
            CLS_SER: begin
                if (n != 4'h0)        o_res.unsup = 1'b1;
                else if (i_vx == i_vy) o_res.pc = pc4;
            end
            CLS_LD: begin
                o_res.wr   = 1'b1;
                o_res.dval = kk;
            end
            CLS_ADD: begin
                o_res.wr   = 1'b1;
                o_res.dval = i_vx + kk;
            end
            CLS_ALU: begin
                o_res.wr = 1'b1;
                unique case (n)
                    ALU_MOV: o_res.dval = i_vy;
                    ALU_OR:  o_res.dval = i_vx | i_vy;
                    ALU_AND: o_res.dval = i_vx & i_vy;
                    ALU_XOR: o_res.dval = i_vx ^ i_vy;
                    ALU_ADD: begin
                        o_res.fw   = 1'b1;
                        o_res.fval = sum[8];
                        o_res.dval = sum[7:0];
                    end
                    ALU_SUB: begin
                        o_res.fw   = 1'b1;
                        o_res.fval = i_vx > i_vy;
                        o_res.dval = i_vx - i_vy;
                    end
                    ALU_SHR: begin
                        o_res.fw   = 1'b1;
                        o_res.fval = i_vx[0];
                        o_res.dval = {1'b0, i_vx[7:1]};
                    end
                    ALU_SBN: begin
                        o_res.fw   = 1'b1;
                        o_res.fval = i_vy > i_vx;
                        o_res.dval = i_vy - i_vx;
                    end
                    ALU_SHL: begin
                        o_res.fw   = 1'b1;
                        o_res.fval = i_vx[7];
                        o_res.dval = {i_vx[6:0], 1'b0};
                    end
                    default: begin
                        o_res.wr    = 1'b0;
                        o_res.unsup = 1'b1;
                    end
                endcase
            end
            CLS_SNER: begin
                if (n != 4'h0)        o_res.unsup = 1'b1;
                else if (i_vx != i_vy) o_res.pc = pc4;
            end
            CLS_LDI:  o_res.index = nnn;
            // i_vy carries V0 for this class
            CLS_JPV0: o_res.pc = {{(ADDR_W-8){1'b0}}, i_vy} + nnn;
            CLS_RND: begin
                o_res.wr   = 1'b1;
                o_res.dval = i_req.random_byte & kk;
            end
            default: o_res.unsup = 1'b1;
        endcase

        if (!o_res.wr) begin
            o_res.x    = '0;
            o_res.dval = '0;
        end
    end

endmodule

[rtl/core/chip8_instruction_execute_core.sv]
// Channel | Direction | Handshake                | Payload
// in      | request   | i_in_valid / o_in_stall  | i_in_data  (t_in)
// out     | result    | o_out_valid / i_out_stall| o_out_data (t_out)
// cfg     | write     | i_cfg_we                 | i_cfg_wdata (program start)
//
// One instruction per cycle sustained while the output is not stalled; a request has
// its register-file and return-stack RAM read, then execute and write back.
// Back-to-back hazards on V registers and the stack are covered by forwarding.
// VF lives in a flop; V0-VE live in a duplicated 1W1R RAM with reset valid bits.
// Synchronous active-low reset: pc = 0x200, index, sp and V registers = 0.
// A stalled output holds the execute stage; the input stalls only when both are full.
module chip8_instruction_execute_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  c8x_pkg::t_in               i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output c8x_pkg::t_out              o_out_data,
    input  logic                       i_cfg_we,
    input  logic [c8x_pkg::ADDR_W-1:0] i_cfg_wdata
);
    import c8x_pkg::*;

    // architectural state kept in flops
    logic [ADDR_W-1:0]   r_pc;
    logic [ADDR_W-1:0]   r_index;
    logic [SP_W-1:0]     r_sp;
    logic [7:0]          r_vf;
    logic [NUM_REGS-1:0] r_vvalid;

    // last V register RAM write, for read-during-write forwarding
    logic                r_fw_valid;
    logic [REG_AW-1:0]   r_fw_addr;
    logic [7:0]          r_fw_data;
    // last stack RAM write
    logic                r_sfw_valid;
    logic [SP_W-1:0]     r_sfw_addr;
    logic [ADDR_W-1:0]   r_sfw_data;

    // execute stage
    logic                r_s1_valid;
    t_in                 r_s1_in;
    logic [REG_AW-1:0]   r_s1_ya;
    logic                r_s1_xok;
    logic                r_s1_yok;
    logic [SP_W-1:0]     r_s1_saddr;

    logic                r_out_valid;
    t_out                r_out;

    logic                in_acc;
    logic                s1_fire;
    logic [REG_AW-1:0]   in_xa;
    logic [REG_AW-1:0]   in_ya;
    logic [SP_W-1:0]     n_sp;
    logic [SP_W-1:0]     stk_raddr;
    logic [REG_AW-1:0]   s1_xa;
    logic [7:0]          q_x;
    logic [7:0]          q_y;
    logic [ADDR_W-1:0]   q_stk;
    logic [7:0]          vx;
    logic [7:0]          vy;
    logic [ADDR_W-1:0]   stk_data;
    t_exec_res           res;
    logic                vreg_we;
    logic                stk_we;

    assign s1_fire    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign in_xa = i_in_data.instruction[11:8];
    assign in_ya = (i_in_data.instruction[15:12] == CLS_JPV0) ? '0 :
                   i_in_data.instruction[7:4];

    // stack pointer as it stands after a commit at this edge
    assign n_sp      = s1_fire ? res.sp : r_sp;
    assign stk_raddr = sp_dec(n_sp);

    assign vreg_we = s1_fire && res.wr && (res.x != VF_IDX);
    assign stk_we  = s1_fire && res.stk_we;

    c8x_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_vram_x (
        .i_clk   (i_clk),
        .i_we    (vreg_we),
        .i_waddr (res.x),
        .i_wdata (res.dval),
        .i_re    (in_acc),
        .i_raddr (in_xa),
        .o_rdata (q_x)
    );

    c8x_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_vram_y (
        .i_clk   (i_clk),
        .i_we    (vreg_we),
        .i_waddr (res.x),
        .i_wdata (res.dval),
        .i_re    (in_acc),
        .i_raddr (in_ya),
        .o_rdata (q_y)
    );

    c8x_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_sp),
        .i_wdata (res.stk_wdata),
        .i_re    (in_acc),
        .i_raddr (stk_raddr),
        .o_rdata (q_stk)
    );

    assign s1_xa = r_s1_in.instruction[11:8];

    always_comb begin
        if (s1_xa == VF_IDX)                          vx = r_vf;
        else if (r_fw_valid && r_fw_addr == s1_xa)    vx = r_fw_data;
        else if (r_s1_xok)                            vx = q_x;
        else                                          vx = '0;

        if (r_s1_ya == VF_IDX)                        vy = r_vf;
        else if (r_fw_valid && r_fw_addr == r_s1_ya)  vy = r_fw_data;
        else if (r_s1_yok)                            vy = q_y;
        else                                          vy = '0;

        if (r_sfw_valid && r_sfw_addr == r_s1_saddr)  stk_data = r_sfw_data;
        else                                          stk_data = q_stk;
    end

    c8x_exec u_exec (
        .i_req      (r_s1_in),
        .i_vx       (vx),
        .i_vy       (vy),
        .i_pc       (r_pc),
        .i_index    (r_index),
        .i_sp       (r_sp),
        .i_ret_sp   (r_s1_saddr),
        .i_stk_data (stk_data),
        .o_res      (res)
    );

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_RESET;
            r_index     <= '0;
            r_sp        <= '0;
            r_vf        <= '0;
            r_vvalid    <= '0;
            r_fw_valid  <= 1'b0;
            r_sfw_valid <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (s1_fire) begin
                r_pc    <= res.pc;
                r_index <= res.index;
                r_sp    <= res.sp;
                // destination beats the flag when x is F
                if (res.wr && res.x == VF_IDX) begin
                    r_vf <= res.dval;
                end else if (res.fw) begin
                    r_vf <= {7'b0, res.fval};
                end
            end

            if (vreg_we) begin
                r_vvalid[res.x] <= 1'b1;
                r_fw_valid      <= 1'b1;
            end
            if (stk_we) begin
                r_sfw_valid <= 1'b1;
            end

            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_in    <= i_in_data;
            r_s1_ya    <= in_ya;
            r_s1_xok   <= r_vvalid[in_xa];
            r_s1_yok   <= r_vvalid[in_ya];
            r_s1_saddr <= stk_raddr;
        end
        if (vreg_we) begin
            r_fw_addr <= res.x;
            r_fw_data <= res.dval;
        end
        if (stk_we) begin
            r_sfw_addr <= r_sp;
            r_sfw_data <= res.stk_wdata;
        end
        if (s1_fire) begin
            r_out.next_pc      <= res.pc;
            r_out.index_value  <= res.index;
            r_out.reg_written  <= res.wr;
            r_out.dest_reg     <= res.x;
            r_out.dest_value   <= res.dval;
            r_out.flag_written <= res.fw;
            r_out.flag_value   <= res.fval;
            r_out.clear_screen <= res.clr;
            r_out.unsupported  <= res.unsup;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_valid)
        else $error("committed request did not reach output register");

    a_accept_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_s1_valid |-> s1_fire)
        else $error("request accepted over a held execute stage");

    a_vf_not_in_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vreg_we |-> res.x != VF_IDX)
        else $error("VF written to register RAM");

    a_unsup_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && res.unsup |-> !res.wr && !res.fw && !res.stk_we)
        else $error("unsupported opcode changed register state");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

endmodule

[test/c8x_exec_checker.sv]
module c8x_exec_checker
    import c8x_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    input  logic i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]        vregs [NUM_REGS];
    logic [ADDR_W-1:0] ret_stack [STACK_DEPTH];
    logic [ADDR_W-1:0] pc_r;
    logic [ADDR_W-1:0] index_r;
    logic [SP_W-1:0]   sp_r;
    t_out              exec_outcomes [$];
    int                fail_count;

    // executes one instruction against the shadow state, returns the update it reports
    function automatic t_out run_instr(input t_in req);
        logic [15:0] op;
        logic [3:0]  x, y;
        logic [7:0]  kk, vx, vy, dval;
        logic [11:0] nnn;
        logic [8:0]  sum;
        logic        wr, fw, fval, clr, unsup;
        t_out        res;
        op    = req.instruction;
        x     = op[11:8];
        y     = op[7:4];
        kk    = op[7:0];
        nnn   = op[11:0];
        vx    = vregs[x];
        vy    = vregs[y];
        wr    = 1'b0;
        fw    = 1'b0;
        fval  = 1'b0;
        clr   = 1'b0;
        unsup = 1'b0;
        dval  = '0;
        pc_r  = pc_r + 12'd2;
        case (op[15:12])
            CLS_SYS: begin
                if (op == OP_CLS) begin
                    clr = 1'b1;
                end else if (op == OP_RET) begin
                    sp_r = sp_r - 1'b1;
                    pc_r = ret_stack[sp_r];
                end else begin
                    unsup = 1'b1;
                end
            end
            CLS_JP: pc_r = nnn;
            CLS_CALL: begin
                ret_stack[sp_r] = pc_r;
                sp_r = sp_r + 1'b1;
                pc_r = nnn;
            end
            CLS_SE:  if (vx == kk) pc_r = pc_r + 12'd2;
            CLS_SNE: if (vx != kk) pc_r = pc_r + 12'd2;
            CLS_SER: begin
                if (op[3:0] != 4'h0) unsup = 1'b1;
                else if (vx == vy) pc_r = pc_r + 12'd2;
            end
            CLS_LD: begin
                wr = 1'b1;
                dval = kk;
            end
            CLS_ADD: begin
                wr = 1'b1;
                dval = vx + kk;
            end
            CLS_ALU: begin
                wr = 1'b1;
                case (op[3:0])
                    ALU_MOV: dval = vy;
                    ALU_OR:  dval = vx | vy;
                    ALU_AND: dval = vx & vy;
                    ALU_XOR: dval = vx ^ vy;
                    ALU_ADD: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        fw = 1'b1;
                        fval = sum[8];
                        dval = sum[7:0];
                    end
                    ALU_SUB: begin
                        fw = 1'b1;
                        fval = vx > vy;
                        dval = vx - vy;
                    end
                    ALU_SHR: begin
                        fw = 1'b1;
                        fval = vx[0];
                        dval = vx >> 1;
                    end
                    ALU_SBN: begin
                        fw = 1'b1;
                        fval = vy > vx;
                        dval = vy - vx;
                    end
                    ALU_SHL: begin
                        fw = 1'b1;
                        fval = vx[7];
                        dval = vx << 1;
                    end
                    default: begin
                        wr = 1'b0;
                        unsup = 1'b1;
                    end
                endcase
            end
            CLS_SNER: begin
                if (op[3:0] != 4'h0) unsup = 1'b1;
                else if (vx != vy) pc_r = pc_r + 12'd2;
            end
            CLS_LDI:  index_r = nnn;
            CLS_JPV0: pc_r = {4'h0, vregs[0]} + nnn;
            CLS_RND: begin
                wr = 1'b1;
                dval = req.random_byte & kk;
            end
            default: unsup = 1'b1;
        endcase
        // flag first so that a VF destination keeps the result
        if (fw) vregs[VF_IDX] = {7'h0, fval};
        if (wr) vregs[x] = dval;
        res.next_pc      = pc_r;
        res.index_value  = index_r;
        res.reg_written  = wr;
        res.dest_reg     = wr ? x : 4'h0;
        res.dest_value   = wr ? dval : 8'h0;
        res.flag_written = fw;
        res.flag_value   = fw & fval;
        res.clear_screen = clr;
        res.unsupported  = unsup;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            foreach (vregs[i]) vregs[i] = '0;
            pc_r    = PC_RESET;
            index_r = '0;
            sp_r    = '0;
            exec_outcomes.delete();
        end else begin
            if (i_cfg_we) pc_r = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (exec_outcomes.size() == 0) begin
                    $display("%0t: result with no request pending, got %h", $time, i_out_data);
                    fail_count++;
                end else begin
                    want = exec_outcomes.pop_front();
                    check_field("next_pc", 32'(want.next_pc), 32'(i_out_data.next_pc));
                    check_field("index_value", 32'(want.index_value),
                                32'(i_out_data.index_value));
                    check_field("reg_written", 32'(want.reg_written),
                                32'(i_out_data.reg_written));
                    check_field("dest_reg", 32'(want.dest_reg), 32'(i_out_data.dest_reg));
                    check_field("dest_value", 32'(want.dest_value),
                                32'(i_out_data.dest_value));
                    check_field("flag_written", 32'(want.flag_written),
                                32'(i_out_data.flag_written));
                    check_field("flag_value", 32'(want.flag_value),
                                32'(i_out_data.flag_value));
                    check_field("clear_screen", 32'(want.clear_screen),
                                32'(i_out_data.clear_screen));
                    check_field("unsupported", 32'(want.unsupported),
                                32'(i_out_data.unsupported));
                end
            end
            if (i_in_valid && !i_in_stall) exec_outcomes.push_back(run_instr(i_in_data));
        end
        o_fail_count = fail_count;
        o_pending    = exec_outcomes.size();
    end

endmodule

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import c8x_pkg::*;

    localparam int LIMIT      = 200000;
    localparam int PHASE_REQS = 280;
    localparam int NUM_DIR    = 30;

    // hand-picked opening sequence; register values chain from one request to the next
    localparam logic [15:0] DIRECTED [NUM_DIR] = '{
        16'h00E0, 16'h6AFF, 16'h6B01, 16'h8AB4, 16'h7AFF, 16'h8AB5,
        16'h8BA5, 16'h8AB7, 16'h8A06, 16'h8AB1, 16'h8AB2, 16'h8AB3,
        16'h8AB0, 16'h6F81, 16'h8FFE, 16'h3A03, 16'h4A03, 16'h5AB0,
        16'h9AB0, 16'h5AB1, 16'h9ABF, 16'h8AB8, 16'hAFFF, 16'h2FFE,
        16'h00EE, 16'h1FFF, 16'hBFFF, 16'hC5A7, 16'hE19E, 16'hFFFF
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    t_in               in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out              out_data;
    logic              cfg_we = 1'b0;
    logic [ADDR_W-1:0] cfg_wdata = '0;

    int                fail_count;
    int                pending;
    int                send_pct = 0;
    int                stall_pct = 0;
    int                cycles = 0;
    logic [SP_W-1:0]        call_sp = '0;
    logic [STACK_DEPTH-1:0] stack_filled = '0;

    chip8_instruction_execute_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    c8x_exec_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_imm();
        logic [7:0] kk;
        kk = 8'($urandom);
        if ($urandom_range(0, 9) < 4) begin
            case ($urandom_range(0, 3))
                0: kk = 8'h00;
                1: kk = 8'h01;
                2: kk = 8'h80;
                default: kk = 8'hFF;
            endcase
        end
        return kk;
    endfunction

    // weighted toward ALU forms and call/return pairs; a return is only issued
    // when the stack slot it pops has been written
    function automatic logic [15:0] pick_instr();
        int              sel;
        int              r;
        logic [3:0]      cls;
        logic [3:0]      n;
        logic [11:0]     low;
        logic [SP_W-1:0] prev_sp;
        logic [15:0]     op;
        sel     = $urandom_range(0, 23);
        cls     = (sel < 16) ? 4'(sel) : (sel < 20) ? CLS_ALU : (sel < 22) ? CLS_CALL : CLS_SYS;
        low     = 12'($urandom);
        prev_sp = call_sp - 1'b1;
        case (cls)
            CLS_SE, CLS_SNE, CLS_LD, CLS_ADD, CLS_RND: low[7:0] = pick_imm();
            CLS_SER, CLS_SNER: if ($urandom_range(0, 7) != 0) low[3:0] = 4'h0;
            CLS_ALU: begin
                if ($urandom_range(0, 7) != 0) begin
                    n = 4'($urandom_range(0, 8));
                    low[3:0] = (n == 4'h8) ? ALU_SHL : n;
                end
            end
            default: ;
        endcase
        op = {cls, low};
        if (cls == CLS_SYS) begin
            r = $urandom_range(0, 9);
            if (r < 5 || op == OP_RET) begin
                op = stack_filled[prev_sp] ? OP_RET : OP_CLS;
            end else if (r < 8) begin
                op = OP_CLS;
            end
        end
        return op;
    endfunction

    task automatic send_req(input logic [15:0] op, input logic [7:0] rnd);
        while ($urandom_range(0, 99) < send_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{instruction: op, random_byte: rnd};
        if (op[15:12] == CLS_CALL) begin
            stack_filled[call_sp] = 1'b1;
            call_sp = call_sp + 1'b1;
        end else if (op == OP_RET) begin
            call_sp = call_sp - 1'b1;
        end
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        logic [ADDR_W-1:0] starts [3];
        int                sender_idle [3];
        int                recv_idle [3];
        starts      = '{12'hFFF, 12'h000, 12'($urandom)};
        sender_idle = '{7, 84, 0};
        recv_idle   = '{84, 7, 0};
        repeat (5) @(negedge clk);
        rst_n     <= 1'b1;
        send_pct  = sender_idle[0];
        stall_pct = recv_idle[0];
        for (int i = 0; i < NUM_DIR; i++) begin
            send_req(DIRECTED[i], i[0] ? 8'hFF : 8'h00);
        end
        for (int p = 0; p < 3; p++) begin
            drain();
            cfg_we    <= 1'b1;
            cfg_wdata <= starts[p];
            @(negedge clk);
            cfg_we    <= 1'b0;
            send_pct  = sender_idle[p];
            stall_pct = recv_idle[p];
            for (int k = 0; k < PHASE_REQS; k++) begin
                if (p == 2 && k == PHASE_REQS / 2) drain();
                send_req(pick_instr(), 8'($urandom));
            end
        end
        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/c8x_pkg.sv
rtl/core/c8x_ram.sv
rtl/core/c8x_exec.sv
rtl/core/chip8_instruction_execute_core.sv
test/c8x_exec_checker.sv
test/tb.sv
